// ===== hdl/blsr_pkg.sv =====
// Shared types, sizes and ring-index helper for the bounded list search block.
package blsr_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int CMD_W   = 3;
  localparam int NC_W    = 5;
  localparam int OUT_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_COUNT     = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_REVERSE   = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Ring slot of base + off, both below DEPTH.
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/bounded_list_search_reverse.sv =====
// Bounded ring-buffer list with insert front/end, count, linear search and reverse.
// Insert, count, reverse and unknown commands, and a search of an empty list, give their
// word the cycle after acceptance; a search reads entries in order and stops on a hit.
// Throughput: one word per cycle unless the output stalls; a search holds off input while
// it reads one entry a cycle. Reset (rst_n low, synchronous) empties the list and clears
// the reverse flag and the pending output word; entry memory contents are not cleared.
module bounded_list_search_reverse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [blsr_pkg::VAL_W-1:0]  in_tdata,   // [31:0] item_value
  input  logic [blsr_pkg::CMD_W-1:0]  in_tuser,   // [2:0] cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [blsr_pkg::OUT_W-1:0]  out_tdata   // [0] found, [5:1] node_count,
                                                  // [6] full_drop, [7] zero
);

  localparam int IDX_W = blsr_pkg::IDX_W;
  localparam int CNT_W = blsr_pkg::CNT_W;
  localparam int VAL_W = blsr_pkg::VAL_W;
  localparam int NC_W  = blsr_pkg::NC_W;

  logic [VAL_W-1:0] mem [blsr_pkg::DEPTH];

  blsr_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0]  front_r;
  logic [CNT_W-1:0]  total_r;
  logic              rev_r;
  logic [VAL_W-1:0]  key_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              cmp_vld_r;
  logic              last_r;
  logic [VAL_W-1:0]  rd_data_r;
  logic              out_valid_r;
  logic [blsr_pkg::OUT_W-1:0] out_data_r;

  logic              in_acc;
  blsr_pkg::cmd_t    cmd;
  logic              full;
  logic              phys_first;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  tail_slot;
  logic [IDX_W-1:0]  scan_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic              ins_ok;
  logic              start_scan;
  logic              issue;
  logic              scan_done;
  logic              load;
  logic              res_found;
  logic              res_drop;
  logic [CNT_W-1:0]  res_cnt;

  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = blsr_pkg::cmd_t'(in_tuser);
  assign full       = (total_r == CNT_W'(blsr_pkg::DEPTH));
  assign phys_first = (cmd == blsr_pkg::CMD_INS_FRONT) != rev_r;
  assign front_dec  = (front_r == '0) ? IDX_W'(blsr_pkg::DEPTH - 1) : front_r - 1'b1;
  assign tail_slot  = blsr_pkg::ring_slot(front_r, total_r[IDX_W-1:0]);
  assign scan_addr  = blsr_pkg::ring_slot(front_r, rd_idx_r[IDX_W-1:0]);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blsr_pkg::ST_IDLE: begin
        if (start_scan) state_nxt = blsr_pkg::ST_SCAN;
      end
      blsr_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = blsr_pkg::ST_IDLE;
      end
      default: state_nxt = blsr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    in_tready  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = tail_slot;
    ins_ok     = 1'b0;
    start_scan = 1'b0;
    issue      = 1'b0;
    scan_done  = 1'b0;
    load       = 1'b0;
    res_found  = 1'b0;
    res_drop   = 1'b0;
    res_cnt    = total_r;
    case (state_r)
      blsr_pkg::ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_acc) begin
          case (cmd)
            blsr_pkg::CMD_INS_FRONT, blsr_pkg::CMD_INS_END: begin
              load = 1'b1;
              if (full) begin
                res_drop = 1'b1;
              end else begin
                ins_ok  = 1'b1;
                mem_we  = 1'b1;
                mem_wa  = phys_first ? front_dec : tail_slot;
                res_cnt = total_r + 1'b1;
              end
            end
            blsr_pkg::CMD_SEARCH: begin
              if (total_r != '0) begin
                start_scan = 1'b1;
              end else begin
                load = 1'b1;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      blsr_pkg::ST_SCAN: begin
        issue     = rd_idx_r < total_r;
        res_found = cmp_vld_r && (rd_data_r == key_r);
        scan_done = res_found || (cmp_vld_r && last_r);
        load      = scan_done;
      end
      default: ;
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_tdata;
    end
    rd_data_r <= mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blsr_pkg::ST_IDLE;
      front_r     <= '0;
      total_r     <= '0;
      rev_r       <= 1'b0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ins_ok) begin
        total_r <= total_r + 1'b1;
        if (phys_first) front_r <= front_dec;
      end
      if (in_acc && (cmd == blsr_pkg::CMD_REVERSE)) begin
        rev_r <= !rev_r;
      end
      // Advance the read pointer; the compare trails it through the registered read data.
      if (start_scan) begin
        rd_idx_r <= '0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      cmp_vld_r <= issue && !scan_done;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) key_r <= in_tdata;
    last_r <= (rd_idx_r == total_r - 1'b1);
    if (load) begin
      out_data_r <= {1'b0, res_drop, NC_W'(res_cnt), res_found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/blsr_checker.sv =====
// Port-level checks for the bounded list search block, bound to its top level.
module blsr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [blsr_pkg::OUT_W-1:0]  out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // An accepted word either yields its result next cycle or holds off input.
  a_in_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid || !in_tready)
    else $error("accepted word neither answered nor holding off input");

  // Count never exceeds the list bound.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (blsr_pkg::DEPTH > 31) ||
                   (out_tdata[5:1] <= 5'(blsr_pkg::DEPTH)))
    else $error("node count above bound");

  // A word never reports both a hit and a dropped insert; pad bit stays zero.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[6]) && !out_tdata[7])
    else $error("inconsistent result flags");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind bounded_list_search_reverse blsr_checker u_blsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/bounded_list_search_reverse_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bounded list with insert, count, search and reverse.
module bounded_list_search_reverse_tb;

  localparam logic [blsr_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [blsr_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int FOUND_BIT  = 0;
  localparam int COUNT_LSB  = 1;
  localparam int DROP_BIT   = 6;
  localparam int RANDOM_OPS = 650;

  typedef struct packed {
    logic [blsr_pkg::CMD_W-1:0] cmd;
    logic [blsr_pkg::VAL_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic                      found;
    logic [blsr_pkg::NC_W-1:0] node_count;
    logic                      full_drop;
  } list_reply_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [blsr_pkg::VAL_W-1:0]   in_tdata;
  logic [blsr_pkg::CMD_W-1:0]   in_tuser;
  logic                         out_tvalid;
  logic                         out_tready;
  logic [blsr_pkg::OUT_W-1:0]   out_tdata;

  bounded_list_search_reverse dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow of the list: ring of slots, first physical slot, length, direction.
  logic [blsr_pkg::VAL_W-1:0] list_slots [blsr_pkg::DEPTH];
  int               head_slot;
  int               list_len;
  bit               list_flipped;

  list_op_t         pending_ops[$];
  list_reply_t      awaited_replies[$];
  logic [blsr_pkg::VAL_W-1:0] key_pool[$];
  list_op_t         next_op;

  int gap_left;
  int stall_left;
  int ops_sent;
  int cycles_run;
  int mismatches;
  int hits_seen;
  int drops_seen;
  int peak_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout after %0d words sent, %0d replies outstanding",
             ops_sent, awaited_replies.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic list_reply_t apply_op(list_op_t op);
    list_reply_t r;
    r = '0;
    case (op.cmd)
      blsr_pkg::CMD_INS_FRONT, blsr_pkg::CMD_INS_END: begin
        if (list_len >= blsr_pkg::DEPTH) begin
          r.full_drop = 1'b1;
        end else if ((op.cmd == blsr_pkg::CMD_INS_FRONT) != list_flipped) begin
          head_slot = (head_slot + blsr_pkg::DEPTH - 1) % blsr_pkg::DEPTH;
          list_slots[head_slot] = op.value;
          list_len++;
        end else begin
          list_slots[(head_slot + list_len) % blsr_pkg::DEPTH] = op.value;
          list_len++;
        end
      end
      blsr_pkg::CMD_SEARCH: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_slots[(head_slot + i) % blsr_pkg::DEPTH] == op.value) r.found = 1'b1;
        end
      end
      blsr_pkg::CMD_REVERSE: begin
        list_flipped = !list_flipped;
      end
      default: begin
      end
    endcase
    r.node_count = blsr_pkg::NC_W'(list_len);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [blsr_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [blsr_pkg::VAL_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (key_pool.size() == 0 || r >= 75) return pick_value();
    if (r < 60) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    // near miss: one bit away from a known value
    return key_pool[$urandom_range(0, key_pool.size() - 1)] ^ (32'd1 << $urandom_range(0, 31));
  endfunction

  task automatic add_op(input logic [blsr_pkg::CMD_W-1:0] cmd,
                        input logic [blsr_pkg::VAL_W-1:0] value);
    list_op_t op;
    op.cmd   = cmd;
    op.value = value;
    pending_ops.push_back(op);
    if (cmd == blsr_pkg::CMD_INS_FRONT || cmd == blsr_pkg::CMD_INS_END) begin
      key_pool.push_back(value);
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic check_reply(input logic [blsr_pkg::OUT_W-1:0] word);
    list_reply_t want;
    if (awaited_replies.size() == 0) begin
      note_mismatch("output word with no reply awaited", 0, int'(word));
    end else begin
      want = awaited_replies.pop_front();
      if (word[FOUND_BIT] !== want.found)
        note_mismatch("found", want.found, word[FOUND_BIT]);
      if (word[COUNT_LSB +: blsr_pkg::NC_W] !== want.node_count)
        note_mismatch("node_count", want.node_count, word[COUNT_LSB +: blsr_pkg::NC_W]);
      if (word[DROP_BIT] !== want.full_drop)
        note_mismatch("full_drop", want.full_drop, word[DROP_BIT]);
    end
    if (word[FOUND_BIT] === 1'b1) hits_seen++;
    if (word[DROP_BIT] === 1'b1) drops_seen++;
    if (int'(word[COUNT_LSB +: blsr_pkg::NC_W]) > peak_count) begin
      peak_count = word[COUNT_LSB +: blsr_pkg::NC_W];
    end
  endtask

  // Driver: hold the current word until taken, then advance after an optional gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        awaited_replies.push_back(apply_op({in_tuser, in_tdata}));
        ops_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        in_tuser  <= next_op.cmd;
        in_tdata  <= next_op.value;
        in_tvalid <= 1'b1;
        gap_left = (((ops_sent / 50) % 4) == 3) ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each word taken, stall out_tready at random outside quiet stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_reply(out_tdata);
      cycles_run++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (((cycles_run / 300) % 4) != 1) stall_left = pick_stall();
      end
    end
  end

  initial begin
    int r;
    int ins_weight;
    logic [blsr_pkg::CMD_W-1:0] cmd;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    head_slot    = 0;
    list_len     = 0;
    list_flipped = 1'b0;
    gap_left   = 0;
    stall_left = 0;
    ops_sent   = 0;
    cycles_run = 0;
    mismatches = 0;
    hits_seen  = 0;
    drops_seen = 0;
    peak_count = 0;

    // directed opening: empty list, extremes, reverse of empty and single entry, spare codes
    add_op(blsr_pkg::CMD_SEARCH,    32'h0000_0000);
    add_op(blsr_pkg::CMD_COUNT,     32'h0000_0000);
    add_op(blsr_pkg::CMD_REVERSE,   32'h0000_0000);
    add_op(blsr_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF);
    add_op(blsr_pkg::CMD_REVERSE,   32'hFFFF_FFFF);
    add_op(blsr_pkg::CMD_INS_FRONT, 32'h8000_0000);
    add_op(blsr_pkg::CMD_INS_END,   32'h0000_0000);
    add_op(blsr_pkg::CMD_REVERSE,   32'h1234_5678);
    add_op(blsr_pkg::CMD_INS_END,   32'hFFFF_FFFF);
    add_op(blsr_pkg::CMD_SEARCH,    32'h8000_0000);
    add_op(blsr_pkg::CMD_SEARCH,    32'h7FFF_FFFF);
    add_op(blsr_pkg::CMD_SEARCH,    32'hFFFF_FFFF);
    add_op(blsr_pkg::CMD_SEARCH,    32'h0000_0001);
    add_op(CMD_SPARE_FIRST,        32'hFFFF_FFFF);
    add_op(CMD_SPARE_FIRST + 3'd1, 32'h0000_0000);
    add_op(CMD_SPARE_LAST,         32'h8000_0000);
    add_op(blsr_pkg::CMD_COUNT,     32'hFFFF_FFFF);
    add_op(blsr_pkg::CMD_SEARCH,    32'hAAAA_AAAA);
    add_op(blsr_pkg::CMD_INS_FRONT, 32'h5555_5555);
    add_op(blsr_pkg::CMD_SEARCH,    32'h5555_5555);
    add_op(blsr_pkg::CMD_SEARCH,    32'h0000_0000);

    // random part: fill slowly while searching and reversing, then run against a full list
    for (int n = 0; n < RANDOM_OPS; n++) begin
      ins_weight = (n < 250) ? 8 : 20;
      r = $urandom_range(0, 99);
      if (r < ins_weight)               cmd = blsr_pkg::CMD_INS_FRONT;
      else if (r < 2 * ins_weight)      cmd = blsr_pkg::CMD_INS_END;
      else if (r < 2 * ins_weight + 10) cmd = blsr_pkg::CMD_COUNT;
      else if (r < 2 * ins_weight + 25) cmd = blsr_pkg::CMD_REVERSE;
      else if (r < 2 * ins_weight + 30) begin
        cmd = blsr_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      else                              cmd = blsr_pkg::CMD_SEARCH;
      if (cmd == blsr_pkg::CMD_SEARCH) add_op(cmd, pick_key());
      else add_op(cmd, pick_value());
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_ops.size() != 0 || in_tvalid || awaited_replies.size() != 0);
    repeat (60) @(posedge clk);

    $display("Sent %0d commands across empty, partly filled and full lists, reversed",
             ops_sent);
    $display("and not; %0d search hits, %0d dropped inserts, peak count %0d.",
             hits_seen, drops_seen, peak_count);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
